// ===== hw/rtl/random_permutation_shuffler_assert.svh =====
// Assertion helpers used by the shuffler RTL.
`ifndef RANDOM_PERMUTATION_SHUFFLER_ASSERT_SVH
`define RANDOM_PERMUTATION_SHUFFLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RPS_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("rps check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define RPS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("rps check failed: next-cycle implication");

`endif

// ===== hw/rtl/rps_pkg.sv =====
`timescale 1ns / 1ps
package rps_pkg;

    localparam int unsigned COUNT_W = 17;
    localparam int unsigned INDEX_W = 16;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned GEN_W   = 64;

    // splitmix64 constants
    localparam logic [GEN_W-1:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [GEN_W-1:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [GEN_W-1:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;
    localparam int unsigned MIX_SHIFT_A   = 30;
    localparam int unsigned MIX_SHIFT_B   = 27;
    localparam int unsigned MIX_SHIFT_OUT = 31;

    // Commands
    localparam logic [1:0] CMD_INIT    = 2'd0;
    localparam logic [1:0] CMD_SHUFFLE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    // Configuration register indexes
    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_SEED        = 1'b1;

    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 17'd65536;
    localparam logic [GEN_W-1:0]   SEED_RESET        = 64'd1;

    typedef struct packed {
        logic [1:0]         command;
        logic [INDEX_W-1:0] entry_index;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] entry_value;
        logic               status;
    } t_out_item;

    // Sequencer -> draw unit
    typedef struct packed {
        logic start;  // draw next random value mod modulus
        logic load;   // load generator from seed
    } t_draw_ctl;

endpackage

// ===== hw/rtl/random_permutation_shuffler.sv =====
// Random permutation shuffler: permutation table in block RAM plus a
// splitmix64 generator, driven by three commands.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one command
// transaction at a time; each gives exactly one result transaction on
// the output channel (o_out_valid / i_out_ready / o_out_data).
// From accept to result valid, with n = min(entry_count, MAX_ENTRIES):
//   init    : n table writes, one per cycle
//   shuffle : (n - 1) swaps, each one waiting on the bit-serial modulo
//             in the draw unit
//   read    : registered RAM read, skipped when the index is flagged
// Only one command is in flight; the next one is taken once the result
// sits in the output register, even while the receiver stalls it.
// The output register holds its transaction until i_out_ready.
// Reset (synchronous, active low) clears control state, the generator
// and restores entry_count = 65536, seed = 1. The table is not cleared;
// entries are defined only after an init command writes them.
// Configuration writes (i_cfg_we) are taken any cycle, no read-back.
`timescale 1ns / 1ps
`include "random_permutation_shuffler_assert.svh"
module random_permutation_shuffler #(
    parameter int unsigned MAX_ENTRIES = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rps_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rps_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [63:0]         i_cfg_data
);
    import rps_pkg::*;

    // table address width and a count width that holds MAX_ENTRIES itself
    localparam int unsigned AW = $clog2(MAX_ENTRIES);
    localparam int unsigned NW = ($clog2(MAX_ENTRIES + 1) > COUNT_W) ?
                                 $clog2(MAX_ENTRIES + 1) : COUNT_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_DRAW   = 4'd2;
    localparam logic [3:0] S_WAIT   = 4'd3;
    localparam logic [3:0] S_RDA    = 4'd4;
    localparam logic [3:0] S_RDB    = 4'd5;
    localparam logic [3:0] S_WRA    = 4'd6;
    localparam logic [3:0] S_WRB    = 4'd7;
    localparam logic [3:0] S_READ   = 4'd8;
    localparam logic [3:0] S_RDWAIT = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    // config registers
    logic [COUNT_W-1:0] r_entry_count;
    logic [GEN_W-1:0]   r_seed;

    // sequencer
    logic [3:0]         r_state, n_state;
    logic [NW-1:0]      r_n, n_n;       // effective count of the command
    logic [NW-1:0]      r_i, n_i;       // init position / Fisher-Yates i
    logic [AW-1:0]      r_j, n_j;       // drawn swap partner
    logic [VALUE_W-1:0] r_a, n_a;       // entry i-1 held during a swap
    logic [INDEX_W-1:0] r_idx, n_idx;
    logic [VALUE_W-1:0] r_val, n_val;
    logic               r_status, n_status;

    // output register
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [NW-1:0]      w_n;
    logic [NW-1:0]      w_im1;
    logic [NW-1:0]      w_idx_ext;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [VALUE_W-1:0] w_wdata;
    logic [AW-1:0]      w_raddr;
    logic [VALUE_W-1:0] w_rdata;

    t_draw_ctl          w_ctl;
    logic               w_draw_done;
    logic [NW-1:0]      w_draw_j;

    // effective count saturates at the table depth
    assign w_n = (NW'(r_entry_count) > NW'(MAX_ENTRIES)) ?
                 NW'(MAX_ENTRIES) : NW'(r_entry_count);
    assign w_im1     = r_i - NW'(1);
    assign w_idx_ext = NW'(r_idx);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= ENTRY_COUNT_RESET;
            r_seed        <= SEED_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ENTRY_COUNT: r_entry_count <= i_cfg_data[COUNT_W-1:0];
                REG_SEED:        r_seed        <= i_cfg_data;
                default:         r_seed        <= r_seed;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_a         = r_a;
        n_idx       = r_idx;
        n_val       = r_val;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = w_im1[AW-1:0];
        w_wdata     = r_a;
        w_raddr     = w_im1[AW-1:0];
        w_ctl       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_n      = w_n;
                    n_val    = '0;
                    n_status = 1'b0;
                    n_idx    = i_in_data.entry_index;
                    unique case (i_in_data.command)
                        CMD_INIT: begin
                            w_ctl.load = 1'b1;
                            n_i        = '0;
                            n_state    = (w_n == '0) ? S_DONE : S_INIT;
                        end
                        CMD_SHUFFLE: begin
                            n_i     = w_n;
                            n_state = (w_n > NW'(1)) ? S_DRAW : S_DONE;
                        end
                        CMD_READ: begin
                            if (NW'(i_in_data.entry_index) < w_n) begin
                                n_state = S_READ;
                            end else begin
                                n_status = 1'b1;
                                n_state  = S_DONE;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_INIT: begin
                // identity fill, one entry per cycle; value wraps at 16 bits
                w_we    = 1'b1;
                w_waddr = r_i[AW-1:0];
                w_wdata = r_i[VALUE_W-1:0];
                if (r_i == r_n - NW'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + NW'(1);
                    n_state = S_INIT;
                end
            end
            S_DRAW: begin
                w_ctl.start = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (w_draw_done) begin
                    n_j     = w_draw_j[AW-1:0];
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                w_raddr = w_im1[AW-1:0];
                n_state = S_RDB;
            end
            S_RDB: begin
                w_raddr = r_j;
                n_a     = w_rdata;
                n_state = S_WRA;
            end
            S_WRA: begin
                w_we    = 1'b1;
                w_waddr = w_im1[AW-1:0];
                w_wdata = w_rdata;
                n_state = S_WRB;
            end
            S_WRB: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_a;
                n_i     = w_im1;
                n_state = (w_im1 > NW'(1)) ? S_DRAW : S_DONE;
            end
            S_READ: begin
                w_raddr = w_idx_ext[AW-1:0];
                n_state = S_RDWAIT;
            end
            S_RDWAIT: begin
                n_val   = w_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.entry_value = r_val;
                    n_out.status      = r_status;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_n      <= n_n;
        r_i      <= n_i;
        r_j      <= n_j;
        r_a      <= n_a;
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_status <= n_status;
        r_out    <= n_out;
    end

    rps_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    rps_draw #(
        .NW (NW)
    ) u_draw (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_modulus (r_i),
        .i_seed    (r_seed),
        .o_done    (w_draw_done),
        .o_j       (w_draw_j)
    );

    // draw results arrive only while the sequencer waits for one
    `RPS_ASSERT_SAME(a_draw_done_in_wait, i_clk, i_rst_n, w_draw_done, r_state == S_WAIT)
    // drawn partner is always below the current Fisher-Yates bound
    `RPS_ASSERT_SAME(a_draw_j_in_range, i_clk, i_rst_n, w_draw_done, w_draw_j < r_i)
    // table writes stay inside the active entries
    `RPS_ASSERT_SAME(a_write_in_range, i_clk, i_rst_n, w_we, NW'(w_waddr) < r_n)
    // a new result is only loaded from the completion state
    `RPS_ASSERT_NEXT(a_out_from_done, i_clk, i_rst_n, (!r_out_valid || i_out_ready) && r_state != S_DONE, !$rose(r_out_valid))

endmodule

// ===== hw/rtl/rps_ram.sv =====
`timescale 1ns / 1ps
module rps_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/rps_draw.sv =====
`timescale 1ns / 1ps
module rps_draw #(
    parameter int unsigned NW = 17
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rps_pkg::t_draw_ctl      i_ctl,
    input  logic [NW-1:0]           i_modulus,
    input  logic [63:0]             i_seed,
    output logic                    o_done,
    output logic [NW-1:0]           o_j
);
    import rps_pkg::*;

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_ADV  = 3'd1;
    localparam logic [2:0] D_PRE1 = 3'd2;
    localparam logic [2:0] D_MUL1 = 3'd3;
    localparam logic [2:0] D_PRE2 = 3'd4;
    localparam logic [2:0] D_MUL2 = 3'd5;
    localparam logic [2:0] D_FIN  = 3'd6;
    localparam logic [2:0] D_DIV  = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [GEN_W-1:0] r_gen, n_gen;
    logic [GEN_W-1:0] r_z, n_z;
    logic [GEN_W-1:0] r_pp, n_pp;
    logic [GEN_W-1:0] r_acc, n_acc;
    logic [1:0]       r_cnt, n_cnt;
    logic [NW-1:0]    r_mod, n_mod;
    logic [NW-1:0]    r_rem, n_rem;
    logic [5:0]       r_bit, n_bit;
    logic             r_done, n_done;

    logic [GEN_W-1:0] w_const;
    logic [31:0]      w_mul_a, w_mul_b;
    logic [63:0]      w_prod;
    logic [NW:0]      w_trial;

    // 64x64 low product from three 32x32 partial products, one per cycle
    assign w_const = (r_state == D_MUL1) ? MIX_MUL_A : MIX_MUL_B;
    assign w_mul_a = (r_cnt == 2'd1) ? r_z[63:32] : r_z[31:0];
    assign w_mul_b = (r_cnt == 2'd2) ? w_const[63:32] : w_const[31:0];
    assign w_prod  = w_mul_a * w_mul_b;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_z[63]};

    always_comb begin
        n_state = r_state;
        n_gen   = r_gen;
        n_z     = r_z;
        n_pp    = r_pp;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_mod   = r_mod;
        n_rem   = r_rem;
        n_bit   = r_bit;
        n_done  = 1'b0;
        unique case (r_state)
            D_IDLE: begin
                if (i_ctl.load) begin
                    n_gen = i_seed ^ GOLDEN_GAMMA;
                end
                if (i_ctl.start) begin
                    n_mod   = i_modulus;
                    n_state = D_ADV;
                end
            end
            D_ADV: begin
                n_gen   = r_gen + GOLDEN_GAMMA;
                n_state = D_PRE1;
            end
            D_PRE1: begin
                n_z     = r_gen ^ (r_gen >> MIX_SHIFT_A);
                n_cnt   = 2'd0;
                n_state = D_MUL1;
            end
            D_MUL1, D_MUL2: begin
                n_cnt = r_cnt + 2'd1;
                case (r_cnt)
                    2'd0: n_pp = w_prod;
                    2'd1: begin
                        n_acc = r_pp;
                        n_pp  = {w_prod[31:0], 32'd0};
                    end
                    2'd2: begin
                        n_acc = r_acc + r_pp;
                        n_pp  = {w_prod[31:0], 32'd0};
                    end
                    default: begin
                        n_acc   = r_acc + r_pp;
                        n_state = (r_state == D_MUL1) ? D_PRE2 : D_FIN;
                    end
                endcase
            end
            D_PRE2: begin
                n_z     = r_acc ^ (r_acc >> MIX_SHIFT_B);
                n_cnt   = 2'd0;
                n_state = D_MUL2;
            end
            D_FIN: begin
                n_z     = r_acc ^ (r_acc >> MIX_SHIFT_OUT);
                n_rem   = '0;
                n_bit   = 6'd63;
                n_state = D_DIV;
            end
            D_DIV: begin
                if (w_trial >= {1'b0, r_mod}) begin
                    n_rem = NW'(w_trial - {1'b0, r_mod});
                end else begin
                    n_rem = w_trial[NW-1:0];
                end
                n_z   = {r_z[62:0], 1'b0};
                n_bit = r_bit - 6'd1;
                if (r_bit == 6'd0) begin
                    n_done  = 1'b1;
                    n_state = D_IDLE;
                end
            end
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_gen   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_gen   <= n_gen;
            r_done  <= n_done;
        end
        r_z   <= n_z;
        r_pp  <= n_pp;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        r_mod <= n_mod;
        r_rem <= n_rem;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_j    = r_rem;

endmodule
